@@ design/sliding_window_share_rate_assert.svh @@
// assertion macros for the share rate meter
`ifndef SLIDING_WINDOW_SHARE_RATE_ASSERT_SVH
`define SLIDING_WINDOW_SHARE_RATE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWSR_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SWSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SWSR_ASSERT_IMPL(label, clk, rst_n, prop)
`define SWSR_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swsr_pkg
// shared widths and types of the share rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package swsr_pkg;
  localparam int unsigned RingDepth = 4096;
  localparam int unsigned AddrW = $clog2(RingDepth);
  localparam int unsigned NumWin = 3;
  localparam int unsigned WinW = 2;
  localparam logic [47:0] TsMask = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CfgShort = 2'd0;
  localparam logic [1:0] CfgMid = 2'd1;
  localparam logic [1:0] CfgLong = 2'd2;

  // ring entry: difficulty and timestamp
  typedef struct packed {
    logic [31:0] diff;
    logic [47:0] ts;
  } ring_entry_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] sum;
    logic [47:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;
endpackage

@@ design/swsr_ring.sv @@
// ----------------------------------------------------------------------------
// swsr_ring
// ring memory of difficulties and timestamps, one write and one read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module swsr_ring
  import swsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  ring_entry_t       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output ring_entry_t       rdata_o
);
  ring_entry_t mem_q [RingDepth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/swsr_div.sv @@
// ----------------------------------------------------------------------------
// swsr_div
// restoring divider, floor(sum * 2^32 / dvs) saturating at all ones, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module swsr_div
  import swsr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [48:0] rem_q;
  logic [63:0] lo_q;
  logic [63:0] quot_q;
  logic [47:0] dvs_q;
  logic        done_q;
  logic [48:0] shifted;
  logic        ge;

  assign shifted = {rem_q[47:0], lo_q[63]};
  assign ge = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dvs_q  <= req_i.dvs;
        lo_q   <= {req_i.sum[31:0], 32'd0};
        quot_q <= '0;
        cnt_q  <= '0;
        rem_q  <= {17'd0, req_i.sum[63:32]};
        // saturation when the high half already reaches the divisor
        if ({16'd0, req_i.sum[63:32]} >= req_i.dvs) begin
          quot_q <= '1;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= ge ? shifted - {1'b0, dvs_q} : shifted;
        lo_q   <= {lo_q[62:0], 1'b0};
        quot_q <= {quot_q[62:0], ge};
        cnt_q  <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule

@@ design/sliding_window_share_rate.sv @@
// ----------------------------------------------------------------------------
// sliding_window_share_rate
// three-window moving difficulty sum and hash rate meter
// ----------------------------------------------------------------------------
// Usage: a share (difficulty, 48-bit ms timestamp) enters on s_axis; one
// result per share leaves on m_axis. Spans are set on the cfg write port
// (index 0 short, 1 mid, 2 long) while the block is idle.
// One share is handled at a time. It is written to the ring memory, then
// each window walks its oldest samples: from the check state it reads the
// second-oldest (when the window holds more than two samples) and then
// the oldest, each through the read, wait and evaluate states; a forced
// eviction reads only the oldest. A divide follows for each window whose
// duration is nonzero. The next share can be taken in the cycle after the
// result is loaded, so the rate is bounded by the single ring read port
// and the shared divider.
// The result sits in an output register; a stalled receiver holds
// m_axis_tdata steady while the next share is already taken and walked,
// and that share waits before its own result until the register is free.
// Reset clears counters, sums, held rates (to zero) and held preliminary
// flags (to one); the ring memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_share_rate_assert.svh"
module sliding_window_share_rate
  import swsr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] share_difficulty, [79:32] timestamp_ms
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] sample_index, [95:32] rate_short_khs, [159:96] rate_mid_khs,
  // [223:160] rate_long_khs, [224] prelim_short, [225] prelim_mid,
  // [226] prelim_long, [229:227] updated_mask, [231:230] zero
  output logic [231:0] m_axis_tdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RD, S_WAIT, S_EVAL, S_DIV, S_NEXT, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] span_q [NumWin];
  logic [31:0] count_q;
  logic [31:0] first_q [NumWin];
  logic [63:0] sum_q [NumWin];
  logic [63:0] rate_q [NumWin];
  logic        prelim_q [NumWin];
  logic [WinW-1:0] win_q;
  logic [31:0] idx_q;
  logic [47:0] ts_q;
  logic [2:0]  mask_q;
  logic        rd_first_q;   // 1: read targets first, 0: first+1
  logic        out_v_q;
  logic [231:0] out_q;
  logic        evict_q;

  logic         ring_we;
  logic [AddrW-1:0] ring_raddr;
  ring_entry_t  ring_rd;
  ring_entry_t  ring_wd;
  div_req_t     dreq;
  div_rsp_t     drsp;

  logic [31:0] cur_first;
  logic [31:0] depth;
  logic [47:0] dts;
  logic [47:0] eff;
  logic        evict_now;

  assign cur_first = first_q[win_q];
  assign depth = idx_q - cur_first;
  assign dts = (ts_q - ring_rd.ts) & TsMask;
  assign eff = (dts < {16'd0, span_q[win_q]}) ? {16'd0, span_q[win_q]} : dts;
  // oldest sample leaves: too deep or second-oldest old enough
  assign evict_now = rd_first_q && (depth >= 32'd2)
                     && ((depth >= RingDepth) || evict_q);

  assign ring_we = s_axis_tvalid && s_axis_tready;
  assign ring_wd.diff = s_axis_tdata[31:0];
  assign ring_wd.ts = s_axis_tdata[79:32];
  assign ring_raddr = rd_first_q ? cur_first[AddrW-1:0]
                                 : cur_first[AddrW-1:0] + AddrW'(1);

  swsr_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ring_wd),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rd)
  );

  assign dreq.start = (state_q == S_EVAL) && rd_first_q && !evict_now && (dts != '0);
  assign dreq.sum = sum_q[win_q];
  assign dreq.dvs = eff;

  swsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  // control sequencer: evict walk, divide, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      win_q <= '0;
      mask_q <= '0;
      rd_first_q <= 1'b0;
      out_v_q <= 1'b0;
      span_q[0] <= 32'd600000;
      span_q[1] <= 32'd3600000;
      span_q[2] <= 32'd86400000;
      for (int w = 0; w < NumWin; w++) begin
        first_q[w] <= '0;
        sum_q[w] <= '0;
        rate_q[w] <= '0;
        prelim_q[w] <= 1'b1;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgShort: span_q[0] <= cfg_data_i;
          CfgMid:   span_q[1] <= cfg_data_i;
          CfgLong:  span_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (ring_we) begin
            idx_q <= count_q;
            ts_q <= s_axis_tdata[79:32];
            count_q <= count_q + 32'd1;
            for (int w = 0; w < NumWin; w++) begin
              sum_q[w] <= sum_q[w] + {32'd0, s_axis_tdata[31:0]};
            end
            win_q <= '0;
            mask_q <= '0;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          // depth overflow or candidate time eviction; else read the oldest only
          if (depth >= RingDepth) begin
            rd_first_q <= 1'b1;
            state_q <= S_RD;
          end else if (depth >= 32'd2) begin
            rd_first_q <= 1'b0;
            state_q <= S_RD;
          end else begin
            rd_first_q <= 1'b1;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WAIT;
        S_WAIT: state_q <= S_EVAL;
        S_EVAL: begin
          if (!rd_first_q) begin
            // second-oldest tested, now read the oldest
            rd_first_q <= 1'b1;
            state_q <= S_RD;
          end else if (evict_now) begin
            // evict oldest
            sum_q[win_q] <= sum_q[win_q] - {32'd0, ring_rd.diff};
            first_q[win_q] <= cur_first + 32'd1;
            state_q <= S_CHK;
          end else if (dts != '0) begin
            prelim_q[win_q] <= dts < {16'd0, span_q[win_q]};
            mask_q[win_q] <= 1'b1;
            state_q <= S_DIV;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            rate_q[win_q] <= drsp.quot;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (win_q == WinW'(NumWin - 1)) begin
            state_q <= S_OUT;
          end else begin
            win_q <= win_q + WinW'(1);
            state_q <= S_CHK;
          end
        end
        S_OUT: begin
          if (!out_v_q) begin
            out_q <= {2'b00, mask_q, prelim_q[2], prelim_q[1], prelim_q[0],
                      rate_q[2], rate_q[1], rate_q[0], idx_q};
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // eviction decision latched from the second-oldest read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evict_q <= 1'b0;
    end else if (state_q == S_EVAL && !rd_first_q) begin
      evict_q <= dts >= {16'd0, span_q[win_q]};
    end else if (state_q == S_CHK) begin
      evict_q <= 1'b0;
    end
  end

  `SWSR_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |-> (state_q == S_IDLE))
  `SWSR_ASSERT_NEXT(a_count_step, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready),
    (count_q == $past(count_q) + 32'd1))
  `SWSR_ASSERT_IMPL(a_div_only_in_walk, clk_i, rst_ni,
    drsp.done |-> (state_q == S_DIV))
endmodule
